// File: rtl/j7s_pkg.sv
`timescale 1ns / 1ps
package j7s_pkg;
    localparam int MAX_OUTER  = 256;
    localparam int MAX_MIDDLE = 64;
    localparam int MAX_INNER  = 64;
    localparam int PLANE_MAX  = (MAX_MIDDLE + 2) * (MAX_INNER + 2);
    localparam int WIN_DEPTH  = 2 * PLANE_MAX + 1;
    localparam int AW         = $clog2(WIN_DEPTH);
    localparam int XW         = $clog2(MAX_OUTER + 2);
    localparam int YW         = $clog2(MAX_MIDDLE + 2);
    localparam int ZW         = $clog2(MAX_INNER + 2);
    localparam int QDEPTH     = 4;
    localparam int QAW        = $clog2(QDEPTH);

    localparam logic [2:0] REG_X_SIZE   = 3'd0;
    localparam logic [2:0] REG_Y_SIZE   = 3'd1;
    localparam logic [2:0] REG_Z_SIZE   = 3'd2;
    localparam logic [2:0] REG_CENTER_W = 3'd3;
    localparam logic [2:0] REG_NEIGH_W  = 3'd4;

    // Work item handed from the front end to the datapath.
    typedef struct packed {
        logic [31:0] c;
        logic [31:0] xm;
        logic [31:0] xp;
        logic [31:0] ym;
        logic [31:0] yp;
        logic [31:0] zm;
        logic [31:0] zp;
        logic        last;
    } j7s_item_t;

    // Q16.16 * Q0.16 with round-half-up: floor((v*w + 2^15) / 2^16).
    function automatic logic signed [33:0] mul_round(input logic signed [49:0] p);
        logic signed [49:0] q;
        q = p + 50'sd32768;
        return q[49:16];
    endfunction
endpackage

// File: rtl/jacobi_stencil_7pt_3d_top.sv
`timescale 1ns / 1ps
// Throughput: one cell per cycle when the result side keeps up.
// Path: the edge that accepts the cell completing its stencil loads the window read
//   register; the result then passes the queue, multiply, sum and saturate registers.
// Reset: synchronous active-low; sizes 64, weights 0.5 and 1/12, positions zero.
//   Window memory is not cleared; only cells of the current volume are read.
module jacobi_stencil_7pt_3d_top import j7s_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_we,
    input  logic [2:0]  cfg_idx,
    input  logic [15:0] cfg_wdata,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [31:0] s_tdata,   // [31:0] cell_value
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // [31:0] new_value
    output logic        m_tlast    // last_point
);
    logic [15:0] cw_reg, nw_reg;
    logic        f_valid, full_soon, q_valid, q_ready;
    j7s_item_t   f_item, q_item;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cw_reg <= 16'd32768;
            nw_reg <= 16'd5461;
        end else if (cfg_we) begin
            if (cfg_idx == REG_CENTER_W) cw_reg <= cfg_wdata;
            if (cfg_idx == REG_NEIGH_W)  nw_reg <= cfg_wdata;
        end
    end

    j7s_front u_front (.aclk, .aresetn, .cfg_we, .cfg_idx, .cfg_wdata,
        .s_valid(s_tvalid), .s_ready(s_tready), .s_data(s_tdata),
        .q_valid(f_valid), .q_full_soon(full_soon), .q_item(f_item));

    j7s_queue u_queue (.aclk, .aresetn, .wr_valid(f_valid), .wr_item(f_item),
        .full_soon, .rd_valid(q_valid), .rd_ready(q_ready), .rd_item(q_item));

    j7s_back u_back (.aclk, .aresetn, .cw(cw_reg), .nw(nw_reg),
        .in_valid(q_valid), .in_ready(q_ready), .in_item(q_item),
        .out_valid(m_tvalid), .out_ready(m_tready), .out_value(m_tdata),
        .out_last(m_tlast));
endmodule

// File: rtl/j7s_front.sv
`timescale 1ns / 1ps
module j7s_front import j7s_pkg::*; (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             cfg_we,
    input  logic [2:0]       cfg_idx,
    input  logic [15:0]      cfg_wdata,
    input  logic             s_valid,
    output logic             s_ready,
    input  logic [31:0]      s_data,
    output logic             q_valid,
    input  logic             q_full_soon,
    output j7s_item_t        q_item
);
    logic [8:0]  x_size_reg;
    logic [6:0]  y_size_reg, z_size_reg;
    logic [XW-1:0] x_reg;
    logic [YW-1:0] y_reg;
    logic [ZW-1:0] z_reg;
    logic [AW-1:0] wp_reg;
    logic [XW-1:0] nx;
    logic [YW-1:0] ny;
    logic [ZW-1:0] nz;
    logic [AW-1:0] row, plane;
    logic          acc_in;
    logic          emit;
    // registered window taps (a memory per tap but xp, written in parallel)
    logic [31:0] mem_c  [WIN_DEPTH];
    logic [31:0] mem_xm [WIN_DEPTH];
    logic [31:0] mem_ym [WIN_DEPTH];
    logic [31:0] mem_yp [WIN_DEPTH];
    logic [31:0] mem_zm [WIN_DEPTH];
    logic [31:0] mem_zp [WIN_DEPTH];
    logic [AW-1:0] a_c, a_xm, a_ym, a_yp, a_zm, a_zp;
    logic        v_reg;

    always_comb begin
        nx = (x_size_reg == 9'd0) ? XW'(1) :
             (x_size_reg > 9'(MAX_OUTER)) ? XW'(MAX_OUTER) : XW'(x_size_reg);
        ny = (y_size_reg == 7'd0) ? YW'(1) :
             (y_size_reg > 7'(MAX_MIDDLE)) ? YW'(MAX_MIDDLE) : YW'(y_size_reg);
        nz = (z_size_reg == 7'd0) ? ZW'(1) :
             (z_size_reg > 7'(MAX_INNER)) ? ZW'(MAX_INNER) : ZW'(z_size_reg);
    end

    // plane length registered from the sizes (to be written only while idle by the user; not enforced)
    logic [AW-1:0] plane_reg, row_reg;
    always_ff @(posedge aclk) begin
        row_reg   <= AW'(nz) + AW'(2);
        plane_reg <= AW'((32'(ny) + 32'd2) * (32'(nz) + 32'd2));
    end
    assign row   = row_reg;
    assign plane = plane_reg;

    function automatic logic [AW-1:0] back(input logic [AW-1:0] p, input logic [AW-1:0] d);
        logic [AW:0] s;
        s = {1'b0, p} - {1'b0, d};
        if (p < d) s = s + (AW+1)'(WIN_DEPTH);
        return s[AW-1:0];
    endfunction

    assign a_c  = back(wp_reg, plane);
    assign a_xm = back(wp_reg, AW'(2 * 32'(plane)));
    assign a_ym = back(wp_reg, plane + row);
    assign a_yp = back(wp_reg, plane - row);
    assign a_zm = back(wp_reg, plane + AW'(1));
    assign a_zp = back(wp_reg, plane - AW'(1));

    assign s_ready = !q_full_soon;
    assign acc_in  = s_valid && s_ready;
    assign emit = (x_reg >= XW'(2)) && (y_reg >= YW'(1)) && (y_reg <= ny) &&
                  (z_reg >= ZW'(1)) && (z_reg <= nz);

    always_ff @(posedge aclk) begin
        if (acc_in) begin
            mem_c[wp_reg]  <= s_data;
            mem_xm[wp_reg] <= s_data;
            mem_ym[wp_reg] <= s_data;
            mem_yp[wp_reg] <= s_data;
            mem_zm[wp_reg] <= s_data;
            mem_zp[wp_reg] <= s_data;
            q_item.c    <= mem_c[a_c];
            q_item.xm   <= mem_xm[a_xm];
            q_item.ym   <= mem_ym[a_ym];
            q_item.yp   <= mem_yp[a_yp];
            q_item.zm   <= mem_zm[a_zm];
            q_item.zp   <= mem_zp[a_zp];
            q_item.xp   <= s_data;
            q_item.last <= (x_reg == nx + XW'(1)) && (y_reg == ny) && (z_reg == nz);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            x_size_reg <= 9'd64;
            y_size_reg <= 7'd64;
            z_size_reg <= 7'd64;
            x_reg <= '0; y_reg <= '0; z_reg <= '0;
            wp_reg <= '0;
            v_reg  <= 1'b0;
        end else begin
            v_reg <= acc_in && emit;
            if (cfg_we && cfg_idx <= REG_NEIGH_W) begin
                if (cfg_idx == REG_X_SIZE) x_size_reg <= cfg_wdata[8:0];
                if (cfg_idx == REG_Y_SIZE) y_size_reg <= cfg_wdata[6:0];
                if (cfg_idx == REG_Z_SIZE) z_size_reg <= cfg_wdata[6:0];
                x_reg <= '0; y_reg <= '0; z_reg <= '0;
            end else if (acc_in) begin
                wp_reg <= (wp_reg == AW'(WIN_DEPTH - 1)) ? '0 : wp_reg + AW'(1);
                if (z_reg == nz + ZW'(1)) begin
                    z_reg <= '0;
                    if (y_reg == ny + YW'(1)) begin
                        y_reg <= '0;
                        x_reg <= (x_reg == nx + XW'(1)) ? '0 : x_reg + XW'(1);
                    end else begin
                        y_reg <= y_reg + YW'(1);
                    end
                end else begin
                    z_reg <= z_reg + ZW'(1);
                end
            end
        end
    end
    assign q_valid = v_reg;

    a_no_emit_in_halo: assert property (@(posedge aclk) disable iff (!aresetn)
        (acc_in && x_reg < XW'(2)) |=> !v_reg)
        else $error("result raised from a halo plane");
    a_wp_range: assert property (@(posedge aclk) disable iff (!aresetn)
        wp_reg < AW'(WIN_DEPTH)) else $error("write pointer out of range");
    a_z_range: assert property (@(posedge aclk) disable iff (!aresetn)
        (z_reg <= nz + ZW'(1)) || $past(cfg_we)) else $error("inner position out of range");
endmodule

// File: rtl/j7s_back.sv
`timescale 1ns / 1ps
module j7s_back import j7s_pkg::*; (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic [15:0] cw,
    input  logic [15:0] nw,
    input  logic        in_valid,
    output logic        in_ready,
    input  j7s_item_t   in_item,
    output logic        out_valid,
    input  logic        out_ready,
    output logic [31:0] out_value,
    output logic        out_last
);
    // three-stage pipe: multiply, sum, saturate
    logic        v1_reg, v2_reg, v3_reg;
    logic        l1_reg, l2_reg, l3_reg;
    logic signed [33:0] p_reg [7];
    logic signed [36:0] s_reg;
    logic [31:0] o_reg;
    logic        adv;
    logic signed [31:0] vv [7];
    logic signed [36:0] sum;

    assign adv      = !v3_reg || out_ready;
    assign in_ready = adv;

    always_comb begin
        vv[0] = in_item.c;  vv[1] = in_item.xm; vv[2] = in_item.xp;
        vv[3] = in_item.ym; vv[4] = in_item.yp; vv[5] = in_item.zm;
        vv[6] = in_item.zp;
        sum = '0;
        for (int i = 0; i < 7; i++) sum = sum + 37'(p_reg[i]);
    end

    always_ff @(posedge aclk) begin
        if (adv) begin
            for (int i = 0; i < 7; i++)
                p_reg[i] <= mul_round(50'(vv[i]) *
                    $signed({1'b0, (i == 0) ? cw : nw}));
            l1_reg <= in_item.last;
            s_reg  <= sum;
            l2_reg <= l1_reg;
            if (s_reg > 37'sd2147483647)       o_reg <= 32'h7FFF_FFFF;
            else if (s_reg < -37'sd2147483648) o_reg <= 32'h8000_0000;
            else                               o_reg <= s_reg[31:0];
            l3_reg <= l2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0; v2_reg <= 1'b0; v3_reg <= 1'b0;
        end else if (adv) begin
            v1_reg <= in_valid; v2_reg <= v1_reg; v3_reg <= v2_reg;
        end
    end

    assign out_valid = v3_reg;
    assign out_value = o_reg;
    assign out_last  = l3_reg;

    a_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        (v3_reg && !out_ready) |=> v3_reg) else $error("result dropped while stalled");
    a_pipe: assert property (@(posedge aclk) disable iff (!aresetn)
        (adv && v2_reg) |=> v3_reg) else $error("pipeline lost an item");
    a_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !adv |=> $stable(o_reg)) else $error("output moved during stall");
endmodule

// File: rtl/j7s_queue.sv
`timescale 1ns / 1ps
module j7s_queue import j7s_pkg::*; (
    input  logic      aclk,
    input  logic      aresetn,
    input  logic      wr_valid,
    input  j7s_item_t wr_item,
    output logic      full_soon,
    output logic      rd_valid,
    input  logic      rd_ready,
    output j7s_item_t rd_item
);
    j7s_item_t     mem [QDEPTH];
    logic [QAW-1:0] wp_reg, rp_reg;
    logic [QAW:0]   cnt_reg;
    logic           rd;

    assign rd_valid  = cnt_reg != '0;
    assign rd        = rd_valid && rd_ready;
    assign rd_item   = mem[rp_reg];
    // one item may still be in flight in the front end
    assign full_soon = cnt_reg >= (QAW+1)'(QDEPTH - 2);

    always_ff @(posedge aclk) begin
        if (wr_valid) mem[wp_reg] <= wr_item;
    end
    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wp_reg <= '0; rp_reg <= '0; cnt_reg <= '0;
        end else begin
            if (wr_valid) wp_reg <= wp_reg + QAW'(1);
            if (rd) rp_reg <= rp_reg + QAW'(1);
            cnt_reg <= cnt_reg + (QAW+1)'(wr_valid) - (QAW+1)'(rd);
        end
    end

    a_no_over: assert property (@(posedge aclk) disable iff (!aresetn)
        !(wr_valid && cnt_reg == (QAW+1)'(QDEPTH) && !rd)) else $error("queue overflow");
endmodule
